// ----- sv/rce_pkg.sv -----
// Shared types and constants for the rotor cipher engine.
// Holds operation codes, register indexes, field widths and the
// command and status structs between controller and datapath.
package rce_pkg;

  // Field widths of the stream beats and the configuration port.
  localparam int unsigned SYM_W        = 7;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned SEL_W        = 3;
  localparam int unsigned ROTORS_W     = 4;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned IDX_W        = 1;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned IN_TUSER_W   = 3;
  localparam int unsigned OUT_TDATA_W  = 8;
  localparam int unsigned OUT_TUSER_W  = 1;

  // Alphabet starts at the space character.
  localparam int unsigned FIRST_CODE   = 32;
  localparam int unsigned ALPHA_MAX    = 95;

  // Register reset values.
  localparam logic [ROTORS_W-1:0] ROTORS_RESET = 4'd3;
  localparam logic [CFG_W-1:0]    ALPHA_RESET  = 7'd95;

  // Operation codes carried in tuser.
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
  localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ROTORS_IN_USE = 1'b0;
  localparam logic [IDX_W-1:0] REG_ALPHABET_LEN  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted input beat
    logic red_init;   // start an offset reduction pass at rotor 0
    logic red_start;  // start the remainder unit on the current offset
    logic red_write;  // write the reduced offset back and move on
    logic decode;     // handle the latched item, issue the first rotor read
    logic mod_entry;  // reduce a stale table entry in the remainder unit
    logic advance;    // take the rotor result, issue the next read or finish
    logic use_mod;    // take the symbol from the remainder unit
    logic out_load;   // move the finished result into the output register
  } rce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_written;  // alphabet length register written this cycle
    logic cipher_go;    // latched item is a good character to cipher
    logic stale;        // table entry read lies beyond the current alphabet
    logic last;         // current rotor is the last of the walk
    logic mod_busy;     // remainder unit working
    logic red_last;     // reduction pass at its last rotor
    logic out_free;     // output register can take a result
  } rce_status_t;

endpackage

// ----- sv/rce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the forward and inverse rotor tables; no dependencies.
module rce_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rce_ctrl.sv -----
// Controller state machine of the rotor cipher engine.
// Sequences decode, the rotor walk, stale entry reduction and offset
// reduction passes; depends on rce_pkg for the command and status structs.
module rce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  rce_pkg::rce_status_t st,
  output rce_pkg::rce_cmd_t    cmd
);

  typedef enum logic [6:0] {
    IDLE      = 7'b0000001,
    RED_START = 7'b0000010,
    RED_WAIT  = 7'b0000100,
    DECODE    = 7'b0001000,
    WALK      = 7'b0010000,
    MOD_WAIT  = 7'b0100000,
    DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   dirty, dirty_next;

  // Offsets need a reduction pass after every alphabet length write.
  always_comb begin
    if (st.len_written) begin
      dirty_next = 1'b1;
    end else if (state == IDLE && dirty) begin
      dirty_next = 1'b0;
    end else begin
      dirty_next = dirty;
    end
  end

  assign s_axis_tready = (state == IDLE) && !dirty;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (dirty) begin
          cmd.red_init = 1'b1;
          state_next   = RED_START;
        end else if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = DECODE;
        end
      end
      RED_START: begin
        cmd.red_start = 1'b1;
        state_next    = RED_WAIT;
      end
      RED_WAIT: begin
        if (!st.mod_busy) begin
          cmd.red_write = 1'b1;
          state_next    = st.red_last ? IDLE : RED_START;
        end
      end
      DECODE: begin
        cmd.decode = 1'b1;
        state_next = st.cipher_go ? WALK : DONE;
      end
      WALK: begin
        if (st.stale) begin
          cmd.mod_entry = 1'b1;
          state_next    = MOD_WAIT;
        end else begin
          cmd.advance = 1'b1;
          if (st.last) begin
            state_next = DONE;
          end
        end
      end
      MOD_WAIT: begin
        if (!st.mod_busy) begin
          cmd.advance = 1'b1;
          cmd.use_mod = 1'b1;
          state_next  = st.last ? DONE : WALK;
        end
      end
      DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      dirty <= 1'b0;
    end else begin
      state <= state_next;
      dirty <= dirty_next;
    end
  end

endmodule

// ----- sv/rce_datapath.sv -----
// Datapath of the rotor cipher engine: configuration registers, item
// registers, rotor offsets, rotor tables, remainder unit and output register.
// Depends on rce_pkg and rce_ram; driven by rce_ctrl through command structs.
module rce_datapath #(
  parameter int MAX_ROTORS = 8,
  parameter int ROTOR_ROWS = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rce_pkg::IDX_W-1:0]          cfg_index,
  input  logic [rce_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [rce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [rce_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [rce_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  input  rce_pkg::rce_cmd_t                  cmd,
  output rce_pkg::rce_status_t               st
);

  localparam int SYM_W   = rce_pkg::SYM_W;
  localparam int CHAR_W  = rce_pkg::CHAR_W;
  localparam int ROT_W   = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
  localparam int ROW_W   = $clog2(ROTOR_ROWS);
  localparam int ADDR_W  = ROT_W + ROW_W;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int CNT_W   = $clog2(MAX_ROTORS + 1);
  localparam int LEN_MAX = (ROTOR_ROWS < rce_pkg::ALPHA_MAX) ? ROTOR_ROWS
                                                             : rce_pkg::ALPHA_MAX;
  localparam int MODC_W  = $clog2(SYM_W);

  localparam logic [SYM_W-1:0]  FIRST_SYM  = SYM_W'(rce_pkg::FIRST_CODE);
  localparam logic [CHAR_W-1:0] FIRST_CHAR = CHAR_W'(rce_pkg::FIRST_CODE);

  // Configuration registers and their saturated values.
  logic [rce_pkg::ROTORS_W-1:0] rotors_cfg;
  logic [rce_pkg::CFG_W-1:0]    alpha_cfg;
  logic [SYM_W-1:0]             len_eff;
  logic [CNT_W-1:0]             nrot_eff;
  logic [ROT_W-1:0]             last_rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotors_cfg <= rce_pkg::ROTORS_RESET;
      alpha_cfg  <= rce_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rce_pkg::REG_ROTORS_IN_USE: rotors_cfg <= cfg_wdata[rce_pkg::ROTORS_W-1:0];
        rce_pkg::REG_ALPHABET_LEN:  alpha_cfg  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (alpha_cfg < 7'd2) begin
      len_eff = 7'd2;
    end else if (alpha_cfg > LEN_MAX) begin
      len_eff = SYM_W'(LEN_MAX);
    end else begin
      len_eff = alpha_cfg;
    end
    if (rotors_cfg == '0) begin
      nrot_eff = CNT_W'(1);
    end else if (rotors_cfg > MAX_ROTORS) begin
      nrot_eff = CNT_W'(MAX_ROTORS);
    end else begin
      nrot_eff = CNT_W'(rotors_cfg);
    end
  end

  assign last_rot = ROT_W'(nrot_eff - CNT_W'(1));
  assign st.len_written = cfg_we && (cfg_index == rce_pkg::REG_ALPHABET_LEN);

  // Latched input beat.
  logic [rce_pkg::OP_W-1:0]  it_op;
  logic                      it_restart;
  logic [CHAR_W-1:0]         it_char;
  logic [rce_pkg::SEL_W-1:0] it_rsel;
  logic [SYM_W-1:0]          it_pos;
  logic [SYM_W-1:0]          it_ent;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op      <= s_axis_tuser[1:0];
      it_restart <= s_axis_tuser[2];
      it_char    <= s_axis_tdata[7:0];
      it_rsel    <= s_axis_tdata[10:8];
      it_pos     <= s_axis_tdata[17:11];
      it_ent     <= s_axis_tdata[24:18];
    end
  end

  // Decode of the latched item.
  logic             is_load, is_enc, is_dec, is_cipher;
  logic             load_bad, char_bad;
  logic [SYM_W-1:0] ent_sym, char_sym;
  logic [CHAR_W-1:0] char_off;

  assign is_load   = (it_op == rce_pkg::OP_LOAD);
  assign is_enc    = (it_op == rce_pkg::OP_ENCRYPT);
  assign is_dec    = (it_op == rce_pkg::OP_DECRYPT);
  assign is_cipher = is_enc || is_dec;
  assign ent_sym   = it_ent - FIRST_SYM;
  assign char_off  = it_char - FIRST_CHAR;
  assign char_sym  = char_off[SYM_W-1:0];
  assign load_bad  = (it_rsel >= MAX_ROTORS) || (it_pos >= len_eff) ||
                     (it_ent < FIRST_SYM) || (ent_sym >= len_eff);
  assign char_bad  = (it_char < FIRST_CHAR) || (char_off >= {1'b0, len_eff});
  assign st.cipher_go = is_cipher && !char_bad;

  // Walk registers.
  logic [ROT_W-1:0] rot;
  logic [SYM_W-1:0] n;
  logic [SYM_W-1:0] off_cur;

  // Rotor offsets, one read port chosen by off_sel.
  logic [SYM_W-1:0] offsets [MAX_ROTORS];
  logic [SYM_W-1:0] off_step [MAX_ROTORS];
  logic [ROT_W-1:0] off_sel;
  logic [SYM_W-1:0] off_rd;

  // Remainder unit registers.
  logic [SYM_W-1:0]  mod_val;
  logic [SYM_W-1:0]  mod_rem;
  logic [MODC_W-1:0] mod_cnt;
  logic              mod_busy;

  // Table read data and symbol recovery.
  logic [SYM_W-1:0] fwd_rdata, inv_rdata, rd_data;
  logic             data_low;
  logic [SYM_W-1:0] data_sym, raw_sym, sym_in, n_new;
  logic [SYM_W:0]   dec_wrap;
  logic [ROT_W-1:0] rot_next, start_rot, iss_rot;
  logic [SYM_W-1:0] iss_n, off_iss, idx_wrap, rd_row;
  logic [SYM_W:0]   idx_sum;
  logic             issue;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_data  = is_enc ? fwd_rdata : inv_rdata;
  assign data_low = rd_data < FIRST_SYM;
  assign data_sym = rd_data - FIRST_SYM;
  assign raw_sym  = data_low ? '0 : data_sym;
  assign st.stale = !data_low && (data_sym >= len_eff);
  assign sym_in   = cmd.use_mod ? mod_rem : raw_sym;

  // Decrypt removes the rotor offset with wrap; encrypt takes the symbol.
  assign dec_wrap = {1'b0, sym_in} + {1'b0, len_eff} - {1'b0, off_cur};
  always_comb begin
    if (is_enc) begin
      n_new = sym_in;
    end else if (sym_in >= off_cur) begin
      n_new = sym_in - off_cur;
    end else begin
      n_new = dec_wrap[SYM_W-1:0];
    end
  end

  assign rot_next  = is_enc ? rot + ROT_W'(1) : rot - ROT_W'(1);
  assign st.last   = is_enc ? (rot == last_rot) : (rot == '0);
  assign start_rot = is_enc ? '0 : last_rot;

  // Next table read: rotor and symbol, offset added for encrypt.
  assign iss_rot = cmd.decode ? start_rot : rot_next;
  assign iss_n   = cmd.decode ? char_sym : n_new;
  assign off_sel = (cmd.red_start || cmd.red_write) ? rot : iss_rot;
  assign off_rd  = offsets[off_sel];
  assign off_iss = (cmd.decode && it_restart) ? '0 : off_rd;
  assign idx_sum = {1'b0, iss_n} + {1'b0, off_iss};
  assign idx_wrap = (idx_sum >= {1'b0, len_eff}) ? SYM_W'(idx_sum - {1'b0, len_eff})
                                                 : idx_sum[SYM_W-1:0];
  assign rd_row  = is_enc ? idx_wrap : iss_n;
  assign rd_addr = {iss_rot, ROW_W'(rd_row)};
  assign issue   = (cmd.decode && st.cipher_go) || (cmd.advance && !st.last);

  // Walk and reduction counter registers.
  always_ff @(posedge clk) begin
    if (cmd.red_init) begin
      rot <= '0;
    end else if (cmd.red_write) begin
      rot <= rot + ROT_W'(1);
    end else if (issue) begin
      rot     <= iss_rot;
      n       <= iss_n;
      off_cur <= off_iss;
    end
  end

  assign st.red_last = (rot == ROT_W'(MAX_ROTORS - 1));

  // Odometer step: a rotor moves when all lower rotors in use wrapped.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int k = 0; k < MAX_ROTORS; k++) begin
      if (carry && (k < nrot_eff)) begin
        off_step[k] = (offsets[k] == len_eff - 7'd1) ? '0 : offsets[k] + 7'd1;
      end else begin
        off_step[k] = offsets[k];
      end
      carry = carry && (offsets[k] == len_eff - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ROTORS; k++) begin
        offsets[k] <= '0;
      end
    end else if (cmd.decode && is_cipher && it_restart) begin
      for (int k = 0; k < MAX_ROTORS; k++) begin
        offsets[k] <= '0;
      end
    end else if (cmd.red_write) begin
      offsets[rot] <= mod_rem;
    end else if (cmd.advance && st.last) begin
      for (int k = 0; k < MAX_ROTORS; k++) begin
        offsets[k] <= off_step[k];
      end
    end
  end

  // Restoring remainder unit: one quotient bit per cycle.
  logic [SYM_W:0] mod_trial;
  assign mod_trial   = {mod_rem, mod_val[SYM_W-1]};
  assign st.mod_busy = mod_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
    end else if (cmd.mod_entry || cmd.red_start) begin
      mod_busy <= 1'b1;
    end else if (mod_busy && mod_cnt == MODC_W'(SYM_W - 1)) begin
      mod_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_entry || cmd.red_start) begin
      mod_val <= cmd.red_start ? off_rd : data_sym;
      mod_rem <= '0;
      mod_cnt <= '0;
    end else if (mod_busy) begin
      if (mod_trial >= {1'b0, len_eff}) begin
        mod_rem <= SYM_W'(mod_trial - {1'b0, len_eff});
      end else begin
        mod_rem <= mod_trial[SYM_W-1:0];
      end
      mod_val <= mod_val << 1;
      mod_cnt <= mod_cnt + MODC_W'(1);
    end
  end

  // Rotor tables; a load writes the forward entry and its inverse.
  logic             tbl_we;
  logic [ADDR_W-1:0] fwd_waddr, inv_waddr;
  logic [SYM_W-1:0] inv_wdata;

  assign tbl_we    = cmd.decode && is_load && !load_bad;
  assign fwd_waddr = {ROT_W'(it_rsel), ROW_W'(it_pos)};
  assign inv_waddr = {ROT_W'(it_rsel), ROW_W'(ent_sym)};
  assign inv_wdata = it_pos + FIRST_SYM;

  rce_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_fwd_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (fwd_waddr),
    .wdata (it_ent),
    .re    (issue && is_enc),
    .raddr (rd_addr),
    .rdata (fwd_rdata)
  );

  rce_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_inv_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (inv_waddr),
    .wdata (inv_wdata),
    .re    (issue && !is_enc),
    .raddr (rd_addr),
    .rdata (inv_rdata)
  );

  // Finished result, then the output register.
  logic [CHAR_W-1:0] res_char;
  logic              res_err;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_err;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      if (is_load) begin
        res_char <= '0;
        res_err  <= load_bad;
      end else if (is_cipher) begin
        res_char <= it_char;
        res_err  <= 1'b1;
      end else begin
        res_char <= '0;
        res_err  <= 1'b1;
      end
    end else if (cmd.advance && st.last) begin
      res_char <= {1'b0, n_new} + FIRST_CHAR;
      res_err  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char <= res_char;
      out_err  <= res_err;
    end
  end

  assign st.out_free    = !out_valid || m_axis_tready;
  assign m_axis_tvalid  = out_valid;
  assign m_axis_tdata   = out_char;
  assign m_axis_tuser   = out_err;

endmodule

// ----- sv/rotor_cipher_engine.sv -----
// Top level of the rotor cipher engine.
// Joins rce_ctrl and rce_datapath; depends on rce_pkg.
//
// Input beats on s_axis carry one item: a table load, an encrypt or a
// decrypt, with the operation and the restart flag in tuser. Every beat
// gives exactly one beat on m_axis: the character in tdata, the error
// flag in tuser. Registers are to be written on the cfg port while idle;
// the block itself does not enforce this. One item is worked at a time.
// A load passes through decode into the result register and then the
// output register; a character does a registered table read for each
// rotor in use, and a new beat is taken once the controller is back in
// IDLE after the result is stored. A table entry left beyond a shortened
// alphabet is first reduced in the remainder unit. After each write of
// alphabet_len it reduces all MAX_ROTORS offsets with s_axis_tready low.
// Reset clears the offsets and loads the register defaults; table contents
// stay undefined until loaded. The output register holds its beat while
// m_axis_tready is low, and the next result waits until it is taken.
module rotor_cipher_engine #(
  parameter int MAX_ROTORS = 8,
  parameter int ROTOR_ROWS = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rce_pkg::IDX_W-1:0]       cfg_index,
  input  logic [rce_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_code[7:0], rotor_sel[10:8], table_pos[17:11], entry_code[24:18]
  input  logic [rce_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op[1:0], restart[2]
  input  logic [rce_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_char[7:0]
  output logic [rce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // error[0]
  output logic [rce_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  rce_pkg::rce_cmd_t    cmd;
  rce_pkg::rce_status_t st;

  rce_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  rce_datapath #(
    .MAX_ROTORS (MAX_ROTORS),
    .ROTOR_ROWS (ROTOR_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ----- sv/rce_checker.sv -----
// Port-level checks of the rotor cipher engine and their bind.
// Depends on rce_pkg and attaches to rotor_cipher_engine.
module rce_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rce_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // No result beat is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat offered right after reset");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // A good result is a load reply or a character inside the alphabet.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tdata == 8'd0) ||
      (m_axis_tdata >= 8'(rce_pkg::FIRST_CODE) &&
       m_axis_tdata <= 8'(rce_pkg::FIRST_CODE + rce_pkg::ALPHA_MAX - 1)))
    else $error("error-free result outside the alphabet");

  // Only one item is in work: ready drops after an accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while an item is in work");

  // An item cannot produce its result in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early after an accepted beat");

endmodule

bind rotor_cipher_engine rce_checker u_rce_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/testbench.sv -----
// Self-checking testbench for rotor_cipher_engine: loads, encrypt, decrypt, passthrough.
// Keeps its own rotor tables and offsets to predict every output beat.
// Depends on rce_pkg and the rotor_cipher_engine RTL.
`timescale 1ns / 100ps

module testbench;
  import rce_pkg::*;

  localparam int MAX_ROTORS = 8;
  localparam int ROTOR_ROWS = 128;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Covers an item still in flight plus the offset reduction after a length write.
  localparam int RECONFIG_PAUSE = MAX_ROTORS * 9 + 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_ITEMS = 35;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic              restart;
    logic [CHAR_W-1:0] char_code;
    logic [SEL_W-1:0]  rotor_sel;
    logic [SYM_W-1:0]  table_pos;
    logic [SYM_W-1:0]  entry_code;
  } rotor_item_t;

  typedef struct {
    logic [CHAR_W-1:0] out_char;
    logic              error;
  } cipher_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // Predictor state: rotor tables, offsets and registers.
  logic [SYM_W-1:0]    fwd_tab [MAX_ROTORS * ROTOR_ROWS];
  logic [SYM_W-1:0]    inv_tab [MAX_ROTORS * ROTOR_ROWS];
  logic [SYM_W-1:0]    rotor_pos [MAX_ROTORS];
  logic [ROTORS_W-1:0] cfg_rotors = ROTORS_RESET;
  logic [CFG_W-1:0]    cfg_alpha = ALPHA_RESET;

  cipher_out_t expected_chars[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          msg_left = 0;
  logic [OP_W-1:0] msg_op = OP_ENCRYPT;

  rotor_cipher_engine #(
    .MAX_ROTORS(MAX_ROTORS),
    .ROTOR_ROWS(ROTOR_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register values as the block applies them, saturated to the legal range.
  function automatic int alpha_len_now();
    if (cfg_alpha < 2) return 2;
    if (cfg_alpha > ALPHA_MAX) return ALPHA_MAX;
    return cfg_alpha;
  endfunction

  function automatic int rotors_now();
    if (cfg_rotors < 1) return 1;
    if (cfg_rotors > MAX_ROTORS) return MAX_ROTORS;
    return cfg_rotors;
  endfunction

  // A stored character becomes a symbol of the current alphabet.
  function automatic int code_to_sym(input logic [SYM_W-1:0] code, input int len);
    if (code < FIRST_CODE) return 0;
    return (int'(code) - int'(FIRST_CODE)) % len;
  endfunction

  // Odometer step: rotor 0 always moves, a wrap to zero carries into the next rotor.
  function automatic void advance_offsets(input int len, input int nrot);
    int k;
    k = 0;
    rotor_pos[0] = (int'(rotor_pos[0]) % len + 1) % len;
    while (rotor_pos[k] == 0 && k + 1 < nrot) begin
      k++;
      rotor_pos[k] = (int'(rotor_pos[k]) % len + 1) % len;
    end
  endfunction

  // Works out the output beat of one accepted item and updates the state.
  function automatic cipher_out_t cipher_predict(input rotor_item_t it);
    cipher_out_t res;
    int len, nrot, n, sym, off, idx, ch, pos, ent, base;
    len = alpha_len_now();
    nrot = rotors_now();
    res.out_char = '0;
    res.error = 1'b0;
    ch = it.char_code;
    pos = it.table_pos;
    ent = it.entry_code;
    base = int'(it.rotor_sel) * ROTOR_ROWS;

    if (it.op == OP_LOAD) begin
      if (it.rotor_sel >= MAX_ROTORS || pos >= len || ent < int'(FIRST_CODE) ||
          ent - int'(FIRST_CODE) >= len) begin
        res.error = 1'b1;
      end else begin
        fwd_tab[base + pos] = ent;
        inv_tab[base + ent - int'(FIRST_CODE)] = pos + int'(FIRST_CODE);
      end
      return res;
    end
    if (it.op == OP_UNUSED) begin
      res.error = 1'b1;
      return res;
    end

    if (it.restart) begin
      foreach (rotor_pos[k]) rotor_pos[k] = '0;
    end

    // Characters outside the alphabet pass through and leave the offsets alone.
    if (ch < int'(FIRST_CODE) || ch - int'(FIRST_CODE) >= len) begin
      res.out_char = ch;
      res.error = 1'b1;
      return res;
    end
    n = ch - int'(FIRST_CODE);

    if (it.op == OP_ENCRYPT) begin
      for (int r = 0; r < nrot; r++) begin
        idx = (n + int'(rotor_pos[r]) % len) % len;
        n = code_to_sym(fwd_tab[r * ROTOR_ROWS + idx], len);
      end
    end else begin
      for (int r = nrot - 1; r >= 0; r--) begin
        sym = code_to_sym(inv_tab[r * ROTOR_ROWS + n], len);
        off = int'(rotor_pos[r]) % len;
        n = (sym >= off) ? sym - off : sym + len - off;
      end
    end

    advance_offsets(len, nrot);
    res.out_char = n + int'(FIRST_CODE);
    return res;
  endfunction

  function automatic rotor_item_t mk_item(input logic [OP_W-1:0] op, input logic restart,
                                          input int ch, input int rsel, input int pos,
                                          input int ent);
    rotor_item_t it;
    it.op = op;
    it.restart = restart;
    it.char_code = ch;
    it.rotor_sel = rsel;
    it.table_pos = pos;
    it.entry_code = ent;
    return it;
  endfunction

  // Mostly messages of good characters; the rest loads, stray characters and the unused op.
  function automatic rotor_item_t random_item();
    rotor_item_t it;
    int len, pick;
    len = alpha_len_now();
    it = mk_item(OP_UNUSED, $urandom_range(0, 1), $urandom_range(0, 255),
                 $urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if (msg_left == 0) begin
        msg_left = $urandom_range(1, 24);
        msg_op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
        it.restart = 1'b1;
      end else begin
        it.restart = ($urandom_range(0, 31) == 0);
      end
      msg_left--;
      it.op = msg_op;
      it.char_code = FIRST_CODE + $urandom_range(0, len - 1);
    end else if (pick < 86) begin
      it.op = OP_LOAD;
      if ($urandom_range(0, 3) != 0) begin
        it.table_pos = $urandom_range(0, len - 1);
        it.entry_code = FIRST_CODE + $urandom_range(0, len - 1);
      end
    end else if (pick < 95) begin
      it.op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic check_result(input logic [CHAR_W-1:0] got_char, input logic got_err);
    cipher_out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("beat with nothing expected", got_char, 8'h00);
      return;
    end
    want = expected_chars.pop_front();
    if (got_char !== want.out_char) report_mismatch("out_char", got_char, want.out_char);
    if (got_err !== want.error) report_mismatch("error", got_err, want.error);
  endtask

  // Sends one beat after a random gap and predicts its result once accepted.
  task automatic send_item(input rotor_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 19) == 0) tx_idle = !tx_idle;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, it.entry_code, it.table_pos, it.rotor_sel, it.char_code};
    s_axis_tuser <= {it.restart, it.op};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    expected_chars.push_back(cipher_predict(it));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  // Both registers are written on back-to-back edges, the alphabet length last.
  task automatic set_config(input logic [CFG_W-1:0] rotors_val,
                            input logic [CFG_W-1:0] alpha_val);
    drain();
    repeat (RECONFIG_PAUSE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROTORS_IN_USE;
    cfg_wdata <= rotors_val;
    @(posedge clk);
    cfg_index <= REG_ALPHABET_LEN;
    cfg_wdata <= alpha_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_rotors = rotors_val[ROTORS_W-1:0];
    cfg_alpha = alpha_val;
  endtask

  // Loads a random permutation into one rotor, covering every symbol.
  task automatic load_rotor(input int rotor, input int len);
    int perm [ALPHA_MAX];
    int j, tmp;
    for (int p = 0; p < len; p++) perm[p] = p;
    for (int p = len - 1; p > 0; p--) begin
      j = $urandom_range(0, p);
      tmp = perm[p];
      perm[p] = perm[j];
      perm[j] = tmp;
    end
    for (int p = 0; p < len; p++) begin
      send_item(mk_item(OP_LOAD, $urandom_range(0, 1), $urandom_range(0, 255), rotor, p,
                        int'(FIRST_CODE) + perm[p]));
    end
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // With empty tables only items that read no table are sent.
  task automatic test_passthrough_and_bad_loads();
    send_item(mk_item(OP_UNUSED, 1'b1, 8'hFF, 7, 127, 127));
    send_item(mk_item(OP_UNUSED, 1'b0, 0, 0, 0, 0));
    send_item(mk_item(OP_ENCRYPT, 1'b1, 0, 0, 0, 0));
    send_item(mk_item(OP_ENCRYPT, 1'b0, 31, 7, 127, 127));
    send_item(mk_item(OP_ENCRYPT, 1'b0, 127, 0, 0, 0));
    send_item(mk_item(OP_DECRYPT, 1'b1, 255, 0, 0, 0));
    send_item(mk_item(OP_DECRYPT, 1'b0, 128, 0, 0, 0));
    // Bad loads: position past the alphabet, entry below or above it.
    send_item(mk_item(OP_LOAD, 1'b0, 0, 7, 95, 126));
    send_item(mk_item(OP_LOAD, 1'b1, 0, 3, 127, 64));
    send_item(mk_item(OP_LOAD, 1'b0, 0, 0, 10, 31));
    send_item(mk_item(OP_LOAD, 1'b0, 0, 0, 10, 127));
    send_item(mk_item(OP_LOAD, 1'b0, 0, 0, 0, 0));
    // Good loads at the extremes; restart has no effect on a load.
    send_item(mk_item(OP_LOAD, 1'b1, 8'hAA, 7, 94, 126));
    send_item(mk_item(OP_LOAD, 1'b0, 0, 0, 0, 32));
  endtask

  // Two-symbol alphabet on all rotors makes the carry ripple through often.
  task automatic test_tiny_alphabet();
    set_config(7'd8, 7'd2);
    for (int r = 0; r < MAX_ROTORS; r++) load_rotor(r, 2);
    run_random(40);
  endtask

  task automatic test_full_alphabet();
    set_config(7'd8, 7'd95);
    for (int r = 0; r < MAX_ROTORS; r++) load_rotor(r, ALPHA_MAX);
    send_item(mk_item(OP_ENCRYPT, 1'b1, 32, 0, 0, 0));
    send_item(mk_item(OP_ENCRYPT, 1'b0, 126, 0, 0, 0));
    send_item(mk_item(OP_ENCRYPT, 1'b0, 126, 0, 0, 0));
    send_item(mk_item(OP_DECRYPT, 1'b1, 32, 0, 0, 0));
    send_item(mk_item(OP_DECRYPT, 1'b0, 126, 0, 0, 0));
    send_item(mk_item(OP_DECRYPT, 1'b0, 32, 7, 127, 127));
  endtask

  // Settings include out-of-range values that saturate and shortened alphabets
  // that leave stale table entries and offsets behind.
  task automatic test_random_settings();
    logic [CFG_W-1:0] rot_list [8];
    logic [CFG_W-1:0] len_list [8];
    rot_list = '{7'd1, 7'd8, 7'd0, 7'd15, 7'd5, 7'd2, 7'd7, 7'h7A};
    len_list = '{7'd95, 7'd3, 7'd1, 7'd96, 7'd0, 7'd127, 7'd50, 7'd7};
    for (int ph = 0; ph < 8; ph++) begin
      set_config(rot_list[ph], len_list[ph]);
      rx_idle = $urandom_range(0, 1);
      run_random(PHASE_ITEMS);
    end
    for (int ph = 0; ph < 2; ph++) begin
      set_config($urandom_range(0, 127), $urandom_range(0, 127));
      run_random(PHASE_ITEMS);
    end
  endtask

  // Result side: check each beat, then stall a random number of cycles.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata, m_axis_tuser[0]);
      stall_left = rx_idle ? $urandom_range(0, 7) : 0;
      if ($urandom_range(0, 19) == 0) rx_idle = !rx_idle;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (rotor_pos[k]) rotor_pos[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough_and_bad_loads();
    test_tiny_alphabet();
    test_full_alphabet();
    test_random_settings();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rce_pkg.sv
sv/rce_ram.sv
sv/rce_ctrl.sv
sv/rce_datapath.sv
sv/rotor_cipher_engine.sv
sv/rce_checker.sv
test/testbench.sv
